FILE: rtl/core/dqu_pkg.sv
// ----------------------------------------------------------------------------
// dqu_pkg
// Shared constants, codes, types and helpers for the double-ended queue unit.
// ----------------------------------------------------------------------------
package dqu_pkg;

  localparam int DEPTH  = 16;
  localparam int WIDTH  = 32;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);

  // Operation codes.
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;

  // Result status codes.
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  // Memory access plan for one operation, from the pointer unit to the datapath.
  typedef struct packed {
    logic              wr_en;
    logic              rd_en;
    logic [ADDR_W-1:0] addr;
    logic [1:0]        status;
    logic [CNT_W-1:0]  count_nxt;
  } dqu_plan_t;

  // (a + b) mod DEPTH for a < DEPTH and b < DEPTH.
  function automatic logic [ADDR_W-1:0] slot_add(input logic [ADDR_W-1:0] a,
                                                 input logic [ADDR_W-1:0] b);
    logic [ADDR_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (ADDR_W + 1)'(DEPTH)) begin
      s = s - (ADDR_W + 1)'(DEPTH);
    end
    return s[ADDR_W-1:0];
  endfunction

endpackage

FILE: rtl/core/dqu_ram.sv
// ----------------------------------------------------------------------------
// dqu_ram
// Generic single-clock RAM, one write port and one read port, registered read.
// ----------------------------------------------------------------------------
module dqu_ram #(
  parameter int DEPTH_P = 16,
  parameter int WIDTH_P = 32
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [$clog2(DEPTH_P)-1:0] wr_addr,
  input  logic [WIDTH_P-1:0]         wr_data,
  input  logic                       rd_en,
  input  logic [$clog2(DEPTH_P)-1:0] rd_addr,
  output logic [WIDTH_P-1:0]         rd_data
);

  logic [WIDTH_P-1:0] mem [DEPTH_P];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read data holds until the next read is issued.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/core/dqu_ptr.sv
// ----------------------------------------------------------------------------
// dqu_ptr
// Head pointer and element count; turns each operation into a slot access.
// ----------------------------------------------------------------------------
module dqu_ptr (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               fire,
  input  logic [1:0]         operation,
  input  logic               at_tail,
  input  logic [3:0]         position,
  output dqu_pkg::dqu_plan_t plan
);
  import dqu_pkg::*;

  logic [ADDR_W-1:0] head_r, head_nxt;
  logic [CNT_W-1:0]  count_r;
  logic              is_full, is_empty, pos_miss;
  logic [CNT_W-1:0]  offset;

  assign is_full  = (count_r == CNT_W'(DEPTH));
  assign is_empty = (count_r == '0);
  assign pos_miss = (32'(position) >= 32'(count_r));
  // Distance of the wanted element from the head; only used when in range.
  assign offset   = at_tail ? (count_r - CNT_W'(1) - CNT_W'(position)) : CNT_W'(position);

  always_comb begin
    plan.wr_en     = 1'b0;
    plan.rd_en     = 1'b0;
    plan.addr      = head_r;
    plan.status    = ST_OK;
    plan.count_nxt = count_r;
    head_nxt       = head_r;
    case (operation)
      OP_INSERT: begin
        if (is_full) begin
          plan.status = ST_FULL;
        end else begin
          plan.wr_en     = 1'b1;
          plan.count_nxt = count_r + CNT_W'(1);
          if (at_tail) begin
            plan.addr = slot_add(head_r, count_r[ADDR_W-1:0]);
          end else begin
            head_nxt  = slot_add(head_r, ADDR_W'(DEPTH - 1));
            plan.addr = head_nxt;
          end
        end
      end
      OP_REMOVE: begin
        if (is_empty) begin
          plan.status = ST_MISS;
        end else begin
          plan.rd_en     = 1'b1;
          plan.count_nxt = count_r - CNT_W'(1);
          if (at_tail) begin
            plan.addr = slot_add(head_r, plan.count_nxt[ADDR_W-1:0]);
          end else begin
            head_nxt = slot_add(head_r, ADDR_W'(1));
          end
        end
      end
      OP_READ: begin
        if (pos_miss) begin
          plan.status = ST_MISS;
        end else begin
          plan.rd_en = 1'b1;
          plan.addr  = slot_add(head_r, offset[ADDR_W-1:0]);
        end
      end
      default: begin
        plan.status = ST_MISS;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
    end else if (fire) begin
      head_r  <= head_nxt;
      count_r <= plan.count_nxt;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("element count above depth");

  a_no_full_write: assert property (@(posedge clk) disable iff (!rst_n)
    is_full |-> !plan.wr_en)
    else $error("write planned into a full store");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    fire && (plan.wr_en || plan.rd_en) && operation != OP_READ |=> !$stable(count_r))
    else $error("insert or remove did not change the count");

endmodule

FILE: rtl/core/double_ended_queue_unit.sv
// ----------------------------------------------------------------------------
// double_ended_queue_unit
// Bounded double-ended queue of DEPTH words held in a ring store RAM.
// ----------------------------------------------------------------------------
// Each input transfer asks for an insert, a remove or a positional read at
// the head or the tail end, and yields exactly one output transfer carrying a
// status, the value removed or read (zero otherwise) and the element count
// after the step. The unit takes one item per cycle while the output is not
// stalled; a result is held in stage one for the RAM's registered read and
// then in the output register. Head pointer and count update at the input
// transfer, so the next item is planned against the new state at once; a write
// lands in the RAM at that same edge, before any later item can read the slot.
// Insert into a full queue returns status 2, remove from an empty queue or a
// read past the count returns status 1, and nothing changes in either case.
module double_ended_queue_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [31:0] item_value, [35:32] position, zero pad
  input  logic [2:0]  in_tuser,   // [1:0] operation, [2] at_tail
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [31:0] read_value, [36:32] occupancy, zero pad
  output logic [1:0]  out_tuser   // [1:0] status
);
  import dqu_pkg::*;

  logic              in_fire, out_free;
  dqu_plan_t         plan;
  logic [WIDTH-1:0]  rd_data;

  // Stage one: waiting for the RAM read data.
  logic              s1_valid_r;
  logic              s1_take_r;
  logic [1:0]        s1_status_r;
  logic [CNT_W-1:0]  s1_count_r;

  // Output register.
  logic              out_valid_r;
  logic [1:0]        out_status_r;
  logic [WIDTH-1:0]  out_value_r;
  logic [CNT_W-1:0]  out_count_r;

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || out_free;
  assign in_fire   = in_tvalid && in_tready;

  dqu_ptr u_ptr (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (in_fire),
    .operation (in_tuser[1:0]),
    .at_tail   (in_tuser[2]),
    .position  (in_tdata[35:32]),
    .plan      (plan)
  );

  dqu_ram #(
    .DEPTH_P (DEPTH),
    .WIDTH_P (WIDTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (in_fire && plan.wr_en),
    .wr_addr (plan.addr),
    .wr_data (in_tdata[WIDTH-1:0]),
    .rd_en   (in_fire && plan.rd_en),
    .rd_addr (plan.addr),
    .rd_data (rd_data)
  );

  // Stage one advances into the output register when that is free; a new
  // transfer refills it in the same cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (out_free) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_take_r   <= plan.rd_en;
      s1_status_r <= plan.status;
      s1_count_r  <= plan.count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  // The RAM data is only meaningful when this item issued a read.
  always_ff @(posedge clk) begin
    if (out_free && s1_valid_r) begin
      out_status_r <= s1_status_r;
      out_value_r  <= s1_take_r ? rd_data : '0;
      out_count_r  <= s1_count_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {3'b000, out_count_r, out_value_r};

  a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !out_free |=> s1_valid_r)
    else $error("pending item lost while output stalled");

  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r == ST_FULL |-> out_count_r == CNT_W'(DEPTH))
    else $error("full status with free space");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r != ST_OK |-> out_value_r == '0)
    else $error("nonzero value on refused or missed operation");

endmodule

FILE: test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for the double-ended queue unit.
// ----------------------------------------------------------------------------
// A shadow deque in the testbench follows every accepted input transfer and
// queues the result that the unit should return. A monitor on the result
// channel compares each result field by field with the oldest queued result.
// The stimulus starts with a directed pass over the empty and full corners.
// Random traffic follows. It swings between filling and draining the queue
// and runs under three idling patterns. One pass holds the result channel off
// for a long stretch while items keep coming.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dqu_pkg::*;

  localparam int CLK_HALF    = 6;
  localparam int RESET_LEN   = 8;
  localparam int STALL_LIMIT = 4000;
  localparam int HOLD_LEN    = 300;
  localparam int DRAIN_WAIT  = 8;
  localparam int PHASE_ITEMS = 400;

  // The operation code that has no meaning.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // One expected result of the unit.
  typedef struct packed {
    logic [1:0]       status;
    logic [WIDTH-1:0] value;
    logic [CNT_W-1:0] occupancy;
  } deque_result_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata   = '0;   // [31:0] item_value, [35:32] position, zero pad
  logic [2:0]  in_tuser   = '0;   // [1:0] operation, [2] at_tail
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;         // [31:0] read_value, [36:32] occupancy, zero pad
  logic [1:0]  out_tuser;         // [1:0] status

  // Shadow copy of the deque state.
  logic [WIDTH-1:0] shadow_store [DEPTH];
  int               shadow_head;
  int               shadow_count;

  deque_result_t    pending_results [$];
  int               error_count;
  int               send_idle_pct;
  int               recv_idle_pct;
  logic             hold_active = 1'b0;
  event             hold_go;

  double_ended_queue_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    forever begin
      #CLK_HALF clk = ~clk;
    end
  end

  // Applies one operation to the shadow deque and returns what the unit
  // should answer. Slots are addressed relative to the head element.
  function automatic deque_result_t deque_apply(input logic [1:0] op, input logic tail,
                                                input logic [WIDTH-1:0] value,
                                                input logic [3:0] pos);
    deque_result_t r;
    int            slot;
    r.status = ST_OK;
    r.value  = '0;
    case (op)
      OP_INSERT: begin
        if (shadow_count >= DEPTH) begin
          r.status = ST_FULL;
        end else if (tail) begin
          slot = (shadow_head + shadow_count) % DEPTH;
          shadow_store[slot] = value;
          shadow_count++;
        end else begin
          shadow_head = (shadow_head + DEPTH - 1) % DEPTH;
          shadow_store[shadow_head] = value;
          shadow_count++;
        end
      end
      OP_REMOVE: begin
        if (shadow_count == 0) begin
          r.status = ST_MISS;
        end else if (tail) begin
          slot = (shadow_head + shadow_count - 1) % DEPTH;
          r.value = shadow_store[slot];
          shadow_count--;
        end else begin
          r.value = shadow_store[shadow_head];
          shadow_head = (shadow_head + 1) % DEPTH;
          shadow_count--;
        end
      end
      OP_READ: begin
        if (int'(pos) >= shadow_count) begin
          r.status = ST_MISS;
        end else begin
          slot = tail ? (shadow_head + shadow_count - 1 - int'(pos)) % DEPTH
                      : (shadow_head + int'(pos)) % DEPTH;
          r.value = shadow_store[slot];
        end
      end
      default: begin
        // The unused operation code changes nothing and reports a miss.
        r.status = ST_MISS;
      end
    endcase
    r.occupancy = CNT_W'(shadow_count);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [WIDTH-1:0] expected,
                                 input logic [WIDTH-1:0] actual);
    $display("%0t: mismatch in %s: expected 0x%0h, got 0x%0h", $realtime, what,
             expected, actual);
    error_count++;
  endtask

  // Offers one item and returns at the edge where the transfer happens. The
  // valid stays high afterwards so that back-to-back items see no gap unless
  // the sender chooses to idle. The shadow deque is stepped at the transfer,
  // which keeps the expected results in acceptance order.
  task automatic send_item(input logic [1:0] op, input logic tail,
                           input logic [WIDTH-1:0] value, input logic [3:0] pos);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {4'b0000, pos, value};
    in_tuser  <= {tail, op};
    do begin
      @(posedge clk);
    end while (!in_tready);
    pending_results.push_back(deque_apply(op, tail, value, pos));
  endtask

  // Stops offering items and waits until every queued result has come back.
  task automatic drain_results;
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // Empty and full corners, both ends, position extremes and the unused
  // operation code. The head-side insert into an empty queue wraps the head
  // pointer below slot zero.
  task automatic test_directed_edges;
    send_item(OP_REMOVE, 1'b0, 32'h1234_5678, 4'd0);
    send_item(OP_REMOVE, 1'b1, 32'h0, 4'd15);
    send_item(OP_READ,   1'b0, 32'h0, 4'd0);
    send_item(OP_UNUSED, 1'b1, 32'hFFFF_FFFF, 4'd15);
    send_item(OP_INSERT, 1'b0, 32'hFFFF_FFFF, 4'd0);
    send_item(OP_INSERT, 1'b1, 32'h0000_0000, 4'd15);
    send_item(OP_READ,   1'b1, 32'h0, 4'd1);
    send_item(OP_READ,   1'b0, 32'h0, 4'd2);
    for (int i = 0; i < DEPTH - 2; i++) begin
      send_item(OP_INSERT, i[0], (i[1] ? 32'hAAAA_5555 : 32'h5555_AAAA) ^ i, 4'(i));
    end
    // The queue is full now, so both inserts are refused.
    send_item(OP_INSERT, 1'b0, 32'hDEAD_BEEF, 4'd0);
    send_item(OP_INSERT, 1'b1, 32'hCAFE_F00D, 4'd0);
    send_item(OP_READ,   1'b1, 32'h0, 4'd15);
    send_item(OP_REMOVE, 1'b1, 32'h0, 4'd0);
  endtask

  // Random traffic. Every few dozen items the mix tilts toward inserts or
  // toward removes, so the queue regularly runs full and runs dry. Reads
  // mostly aim at live elements, with the rest at random positions.
  task automatic test_random_traffic(input int count);
    int         insert_pct;
    int         pick;
    logic [1:0] op;
    logic [3:0] pos;
    insert_pct = 50;
    for (int i = 0; i < count; i++) begin
      if (i % 32 == 0) begin
        insert_pct = $urandom_range(1) ? 80 : 20;
      end
      pick = $urandom_range(99);
      if (pick < 2) begin
        op = OP_UNUSED;
      end else if (pick < 30) begin
        op = OP_READ;
      end else begin
        op = ($urandom_range(99) < insert_pct) ? OP_INSERT : OP_REMOVE;
      end
      if (op == OP_READ && shadow_count > 0 && $urandom_range(99) < 70) begin
        pos = 4'($urandom_range(shadow_count - 1));
      end else begin
        pos = 4'($urandom_range(15));
      end
      send_item(op, 1'($urandom_range(1)), $urandom, pos);
    end
  endtask

  // Holds the result channel off for a long stretch while items keep coming,
  // so the unit fills its pipeline and must stall its input.
  task automatic test_output_stall;
    -> hold_go;
    for (int i = 0; i < 40; i++) begin
      send_item(i[0] ? OP_INSERT : OP_READ, i[1], $urandom, 4'($urandom_range(15)));
    end
  endtask

  // Long hold-off of the result channel, counted in cycles here.
  initial begin
    forever begin
      @hold_go;
      @(posedge clk);
      hold_active <= 1'b1;
      repeat (HOLD_LEN) @(posedge clk);
      hold_active <= 1'b0;
    end
  end

  // Result monitor and receiver. Signals are sampled at the edge before any
  // nonblocking update lands, then the ready for the next cycle is chosen.
  always @(posedge clk) begin
    deque_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result transfer with no result expected", $realtime);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_tuser !== want.status) begin
          report_mismatch("status", WIDTH'(want.status), WIDTH'(out_tuser));
        end
        if (out_tdata[31:0] !== want.value) begin
          report_mismatch("read_value", want.value, out_tdata[31:0]);
        end
        if (out_tdata[36:32] !== want.occupancy) begin
          report_mismatch("occupancy", WIDTH'(want.occupancy), WIDTH'(out_tdata[36:32]));
        end
        if (out_tdata[39:37] !== 3'b000) begin
          report_mismatch("tdata pad", '0, WIDTH'(out_tdata[39:37]));
        end
      end
    end
    out_tready <= hold_active ? 1'b0 : ($urandom_range(99) >= recv_idle_pct);
  end

  // Watchdog: ends the run when no transfer happens for too long.
  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("%0t: no transfer for %0d cycles", $realtime, STALL_LIMIT);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    error_count   = 0;
    shadow_head   = 0;
    shadow_count  = 0;
    send_idle_pct = 7;
    recv_idle_pct = 53;
    repeat (RESET_LEN) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_edges;
    test_random_traffic(PHASE_ITEMS);
    drain_results;

    send_idle_pct = 53;
    recv_idle_pct = 7;
    test_random_traffic(PHASE_ITEMS);
    drain_results;

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_output_stall;
    test_random_traffic(PHASE_ITEMS);
    drain_results;

    // Let any stray result surface before the verdict.
    repeat (DRAIN_WAIT) @(posedge clk);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
